FILE: sv/bsv_pkg.sv
// Package: shared types and constants of the bencode stream validator.
`default_nettype none
package bsv_pkg;

  // Parser mode, one-hot
  typedef enum logic [4:0] {
    MODE_EXPECT = 5'b00001,
    MODE_INT    = 5'b00010,
    MODE_LEN    = 5'b00100,
    MODE_STR    = 5'b01000,
    MODE_BOOL   = 5'b10000
  } mode_t;

  // Container stack slot codes; NONE stands for the top level
  localparam logic [1:0] SLOT_LIST = 2'd0;
  localparam logic [1:0] SLOT_DKEY = 2'd1;
  localparam logic [1:0] SLOT_DVAL = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  // Token kinds
  localparam logic [2:0] KIND_LIST   = 3'd0;
  localparam logic [2:0] KIND_DICT   = 3'd1;
  localparam logic [2:0] KIND_CLOSE  = 3'd2;
  localparam logic [2:0] KIND_INT    = 3'd3;
  localparam logic [2:0] KIND_LEN    = 3'd4;
  localparam logic [2:0] KIND_BYTE   = 3'd5;
  localparam logic [2:0] KIND_BOOL   = 3'd6;
  localparam logic [2:0] KIND_STATUS = 3'd7;

  // Status codes
  localparam logic [2:0] ST_RUN     = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_INVALID = 3'd2;
  localparam logic [2:0] ST_SHORT   = 3'd3;
  localparam logic [2:0] ST_TRAIL   = 3'd4;
  localparam logic [2:0] ST_DEEP    = 3'd5;

  // Number faults
  localparam logic [2:0] FAULT_BAD  = 3'b001;
  localparam logic [2:0] FAULT_OVF  = 3'b010;
  localparam logic [2:0] FAULT_ZERO = 3'b100;

  localparam logic [4:0] NUM_CHAR_LIMIT = 5'd21;

  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_I     = 8'h69;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;

  // Result item
  typedef struct packed {
    logic        done;
    logic [2:0]  status;
    logic        key;
    logic [8:0]  level;
    logic [63:0] value;
    logic [2:0]  kind;
  } result_t;

endpackage
`default_nettype wire

FILE: sv/bencode_stream_validator.sv
// Top level: streaming bencode validator and tokeniser.
// One byte is taken per cycle and its result item, if any, appears in the
// output register the next cycle; a new byte is accepted every cycle while
// the output register is empty or being drained. The nesting stack keeps its
// top entry and the entry beneath it in registers; the rest sits in a memory
// written on an open and read on a close, one registered access per cycle.
// Stack entries are written before they are read, so no clearing pass is
// needed after reset.
`default_nettype none
module bencode_stream_validator #(
  parameter int MAX_NESTING = 256,
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,     // data_byte
  input  wire logic        in_tlast,     // end_of_message
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [79:0]      out_tdata,    // token_kind[2:0], token_value[66:3],
                                         // nesting_level[75:67], is_dict_key[76],
                                         // status[79:77]
  output logic             out_tlast,    // message_done
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [8:0]  cfg_data      // max_depth
);

  localparam int SW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;
  localparam int DW = $clog2(MAX_NESTING + 1);

  bsv_pkg::mode_t mode_r, mode_nxt;
  logic [1:0]    stack_r [MAX_NESTING];
  logic [1:0]    top_r, top_nxt;
  logic [1:0]    below_r;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [63:0]   mag_r, mag_nxt;
  logic          neg_r, neg_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic [2:0]    flt_r, flt_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic          topc_r, topc_nxt;
  logic          hold_r, hold_nxt;
  logic [8:0]    maxd_r;
  logic          ov_r;
  bsv_pkg::result_t res_r, res;
  logic          have;

  // stack push and pop
  logic          push;
  logic          pop;
  logic [SW-1:0] wr_idx;
  logic [SW-1:0] rd_idx;

  logic [7:0]  c;
  logic        accept;
  logic [1:0]  top;
  logic        keyslot;
  logic [10:0] lim;
  logic        allow_minus;
  logic [63:0] n_mag;
  logic        n_neg;
  logic [4:0]  n_cnt;
  logic [2:0]  n_flt;
  logic        num_bad;
  logic [2:0]  status;
  logic        done;
  logic [DW:0] dep_ext;
  logic [10:0] dep11;

  assign c          = in_tdata;
  assign in_tready  = !ov_r || out_tready;
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata  = {res_r.status, res_r.key, res_r.level, res_r.value, res_r.kind};
  assign out_tlast  = res_r.done;

  assign dep_ext = {1'b0, depth_r};
  assign dep11   = 11'(dep_ext);
  assign wr_idx  = SW'(dep_ext - (DW+1)'(1));
  assign rd_idx  = SW'(dep_ext - (DW+1)'(3));
  assign top     = (depth_r == '0) ? bsv_pkg::SLOT_NONE : top_r;
  assign keyslot = (top == bsv_pkg::SLOT_DKEY);
  assign lim     = (11'(maxd_r) < 11'(MAX_NESTING)) ? 11'(maxd_r) : 11'(MAX_NESTING);
  assign allow_minus = (mode_r == bsv_pkg::MODE_INT);

  bsv_num u_num (
    .ch(c), .allow_minus(allow_minus),
    .mag((mode_r == bsv_pkg::MODE_EXPECT) ? 64'd0 : mag_r),
    .neg((mode_r == bsv_pkg::MODE_EXPECT) ? 1'b0 : neg_r),
    .cnt((mode_r == bsv_pkg::MODE_EXPECT) ? 5'd0 : cnt_r),
    .faults((mode_r == bsv_pkg::MODE_EXPECT) ? 3'd0 : flt_r),
    .mag_nxt(n_mag), .neg_nxt(n_neg), .cnt_nxt(n_cnt), .faults_nxt(n_flt)
  );

  assign num_bad = (flt_r != 3'd0) || (cnt_r == 5'd0) ||
                   (cnt_r >= bsv_pkg::NUM_CHAR_LIMIT) || (cnt_r == {4'd0, neg_r});

  // Byte decode
  always_comb begin
    logic fin;
    logic [DW-1:0] dfin;
    mode_nxt  = mode_r;
    depth_nxt = depth_r;
    mag_nxt   = mag_r;
    neg_nxt   = neg_r;
    cnt_nxt   = cnt_r;
    flt_nxt   = flt_r;
    left_nxt  = left_r;
    topc_nxt  = topc_r;
    hold_nxt  = hold_r;
    push      = 1'b0;
    pop       = 1'b0;
    top_nxt   = top_r;
    have      = 1'b0;
    status    = bsv_pkg::ST_RUN;
    done      = 1'b0;
    fin       = 1'b0;
    dfin      = depth_r;
    res.kind  = bsv_pkg::KIND_STATUS;
    res.value = 64'd0;
    res.level = 9'(depth_r);
    res.key   = 1'b0;
    res.status = bsv_pkg::ST_RUN;
    res.done  = 1'b0;

    if (topc_r) begin
      status = bsv_pkg::ST_TRAIL;
    end else begin
      case (mode_r)
        bsv_pkg::MODE_EXPECT: begin
          if (c == bsv_pkg::CH_E && depth_r != '0 && top != bsv_pkg::SLOT_DVAL) begin
            depth_nxt = depth_r - DW'(1);
            pop = 1'b1;
            top_nxt = (dep11 >= 11'd2) ? below_r : bsv_pkg::SLOT_LIST;
            have = 1'b1; res.kind = bsv_pkg::KIND_CLOSE; res.level = 9'(depth_nxt);
            fin = 1'b1; dfin = depth_nxt;
          end else if (dep11 + 11'd1 > lim) begin
            status = bsv_pkg::ST_DEEP;
          end else if (c == bsv_pkg::CH_L || c == bsv_pkg::CH_D) begin
            if (keyslot || dep_ext >= (DW+1)'(MAX_NESTING)) begin
              status = bsv_pkg::ST_INVALID;
            end else begin
              have = 1'b1;
              res.kind = (c == bsv_pkg::CH_L) ? bsv_pkg::KIND_LIST : bsv_pkg::KIND_DICT;
              push = 1'b1;
              top_nxt = (c == bsv_pkg::CH_L) ? bsv_pkg::SLOT_LIST : bsv_pkg::SLOT_DKEY;
              depth_nxt = depth_r + DW'(1);
            end
          end else if (c == bsv_pkg::CH_I) begin
            mag_nxt = 64'd0; neg_nxt = 1'b0; cnt_nxt = 5'd0; flt_nxt = 3'd0;
            mode_nxt = bsv_pkg::MODE_INT;
          end else if (c == bsv_pkg::CH_B) begin
            if (keyslot) status = bsv_pkg::ST_INVALID;
            else mode_nxt = bsv_pkg::MODE_BOOL;
          end else if (c >= bsv_pkg::CH_0 && c <= bsv_pkg::CH_9) begin
            mag_nxt = n_mag; neg_nxt = n_neg; cnt_nxt = n_cnt; flt_nxt = n_flt;
            mode_nxt = bsv_pkg::MODE_LEN;
          end else begin
            status = bsv_pkg::ST_INVALID;
          end
        end
        bsv_pkg::MODE_INT: begin
          if (c == bsv_pkg::CH_E) begin
            if (num_bad) begin
              status = bsv_pkg::ST_INVALID;
            end else begin
              have = 1'b1; res.kind = bsv_pkg::KIND_INT; res.key = keyslot;
              res.value = neg_r ? (64'd0 - mag_r) : mag_r;
              fin = 1'b1;
            end
          end else begin
            mag_nxt = n_mag; neg_nxt = n_neg; cnt_nxt = n_cnt; flt_nxt = n_flt;
          end
        end
        bsv_pkg::MODE_LEN: begin
          if (c == bsv_pkg::CH_COLON) begin
            if (num_bad || neg_r || (mag_r >> LENGTH_BITS) != 64'd0) begin
              status = bsv_pkg::ST_INVALID;
            end else begin
              have = 1'b1; res.kind = bsv_pkg::KIND_LEN; res.key = keyslot;
              res.value = mag_r;
              if (mag_r == 64'd0) begin
                fin = 1'b1;
              end else begin
                left_nxt = LENGTH_BITS'(mag_r);
                mode_nxt = bsv_pkg::MODE_STR;
              end
            end
          end else begin
            mag_nxt = n_mag; neg_nxt = n_neg; cnt_nxt = n_cnt; flt_nxt = n_flt;
          end
        end
        bsv_pkg::MODE_STR: begin
          have = 1'b1; res.kind = bsv_pkg::KIND_BYTE; res.key = keyslot;
          res.value = {56'd0, c};
          if (left_r != '0) left_nxt = left_r - LENGTH_BITS'(1);
          if (left_r <= LENGTH_BITS'(1)) fin = 1'b1;
        end
        bsv_pkg::MODE_BOOL: begin
          if (c == bsv_pkg::CH_0 || c == bsv_pkg::CH_1) begin
            have = 1'b1; res.kind = bsv_pkg::KIND_BOOL;
            res.value = {63'd0, c[0]};
            fin = 1'b1;
          end else begin
            status = bsv_pkg::ST_INVALID;
          end
        end
        default: status = bsv_pkg::ST_INVALID;
      endcase
    end

    // value finished: flip dict key/value slot or mark top complete
    if (fin) begin
      mode_nxt = bsv_pkg::MODE_EXPECT;
      if (dfin == '0) begin
        topc_nxt = 1'b1;
      end else if (top_nxt == bsv_pkg::SLOT_DKEY) begin
        top_nxt = bsv_pkg::SLOT_DVAL;
      end else if (top_nxt == bsv_pkg::SLOT_DVAL) begin
        top_nxt = bsv_pkg::SLOT_DKEY;
      end
    end

    if (status != bsv_pkg::ST_RUN) begin
      have = 1'b1; done = 1'b1;
      res.kind = bsv_pkg::KIND_STATUS; res.value = 64'd0; res.key = 1'b0;
      res.level = 9'(depth_r);
    end else if (in_tlast) begin
      status = topc_nxt ? bsv_pkg::ST_DONE : bsv_pkg::ST_SHORT;
      have = 1'b1; done = 1'b1;
    end
    res.status = status;
    res.done   = done;

    if (done && !in_tlast) hold_nxt = 1'b1;

    // error hold swallows everything, final byte restarts
    if (hold_r) begin
      have = 1'b0; push = 1'b0; pop = 1'b0; top_nxt = top_r;
      mode_nxt = mode_r; depth_nxt = depth_r; topc_nxt = topc_r; hold_nxt = hold_r;
    end
    if ((hold_r || done) && in_tlast) begin
      mode_nxt = bsv_pkg::MODE_EXPECT; depth_nxt = '0;
      mag_nxt = 64'd0; neg_nxt = 1'b0; cnt_nxt = 5'd0; flt_nxt = 3'd0;
      left_nxt = '0; topc_nxt = 1'b0; hold_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= bsv_pkg::MODE_EXPECT;
      depth_r <= '0;
      top_r   <= bsv_pkg::SLOT_LIST;
      mag_r   <= 64'd0;
      neg_r   <= 1'b0;
      cnt_r   <= 5'd0;
      flt_r   <= 3'd0;
      left_r  <= '0;
      topc_r  <= 1'b0;
      hold_r  <= 1'b0;
      maxd_r  <= 9'd256;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_valid) maxd_r <= cfg_data;
      if (accept) begin
        mode_r  <= mode_nxt;
        depth_r <= depth_nxt;
        top_r   <= top_nxt;
        mag_r   <= mag_nxt;
        neg_r   <= neg_nxt;
        cnt_r   <= cnt_nxt;
        flt_r   <= flt_nxt;
        left_r  <= left_nxt;
        topc_r  <= topc_nxt;
        hold_r  <= hold_nxt;
        ov_r    <= have;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Stack memory below the top entry, next entry down read ahead; result payload
  always_ff @(posedge clk) begin
    if (accept && push) begin
      if (depth_r != '0) stack_r[wr_idx] <= top_r;
      below_r <= top_r;
    end else if (accept && pop && dep11 >= 11'd3) begin
      below_r <= stack_r[rd_idx];
    end
    if (accept) res_r <= res;
  end

endmodule
`default_nettype wire

FILE: sv/bsv_num.sv
// Number accumulator step: one decimal character folded into the running magnitude.
`default_nettype none
module bsv_num (
  input  wire logic [7:0]  ch,
  input  wire logic        allow_minus,
  input  wire logic [63:0] mag,
  input  wire logic        neg,
  input  wire logic [4:0]  cnt,
  input  wire logic [2:0]  faults,
  output logic [63:0]      mag_nxt,
  output logic             neg_nxt,
  output logic [4:0]       cnt_nxt,
  output logic [2:0]       faults_nxt
);

  logic        is_digit;
  logic        ovf_seen;
  logic [3:0]  d;
  logic [63:0] limit;
  logic [67:0] prod;
  logic [67:0] sum;

  assign is_digit = (ch >= bsv_pkg::CH_0) && (ch <= bsv_pkg::CH_9);
  assign ovf_seen = |(faults & bsv_pkg::FAULT_OVF);
  assign d        = 4'(ch - bsv_pkg::CH_0);
  assign limit    = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
  // times ten as shift-add; overflow when the result exceeds the limit
  assign prod     = {1'b0, mag, 3'b000} + {3'b000, mag, 1'b0};
  assign sum      = prod + {64'd0, d};

  always_comb begin
    mag_nxt    = mag;
    neg_nxt    = neg;
    faults_nxt = faults;
    cnt_nxt    = (cnt < bsv_pkg::NUM_CHAR_LIMIT) ? cnt + 5'd1 : cnt;
    if (cnt == 5'd0 && ch == bsv_pkg::CH_MINUS && allow_minus) begin
      neg_nxt = 1'b1;
    end else if (is_digit) begin
      if ((cnt > {4'd0, neg}) && mag == 64'd0 && !ovf_seen)
        faults_nxt = faults_nxt | bsv_pkg::FAULT_ZERO;
      if (neg && cnt == 5'd1 && d == 4'd0)
        faults_nxt = faults_nxt | bsv_pkg::FAULT_ZERO;
      if (!ovf_seen) begin
        if (sum > {4'd0, limit})
          faults_nxt = faults_nxt | bsv_pkg::FAULT_OVF;
        else
          mag_nxt = sum[63:0];
      end
    end else begin
      faults_nxt = faults | bsv_pkg::FAULT_BAD;
    end
  end

endmodule
`default_nettype wire

FILE: tb/bencode_stream_validator_tb.sv
// Testbench: bencode stream validator checked item by item against a behavioural predictor.
`default_nettype none
module bencode_stream_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEST = 256;
  localparam int LBITS = 32;
  localparam int CHARS = 21;
  localparam int WATCHDOG = 20000;

  // predicted token
  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [8:0]  level;
    logic        key;
    logic [2:0]  status;
    logic        done;
  } token_t;

  // directed row: byte, last flag, whether the expected token is typed in
  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         typed;
    bit         has_tok;
    token_t     tok;
  } row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [7:0] in_tdata;
  logic out_tvalid, out_tready, out_tlast;
  logic [79:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [8:0] cfg_data;

  bencode_stream_validator uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // predictor state
  logic [8:0]     p_max_depth;
  bsv_pkg::mode_t p_mode;
  logic [1:0]     p_stack [NEST];
  int unsigned    p_depth;
  logic [63:0]    p_mag;
  bit             p_neg;
  int unsigned    p_chars;
  logic [2:0]     p_faults;
  logic [63:0]    p_left;
  bit             p_top_done;
  bit             p_err_hold;

  token_t expected_tokens[$];
  int     fail_count = 0;
  int     idle_cycles = 0;
  bit     no_gaps = 1'b0;

  function automatic void clear_num();
    p_mag = '0; p_neg = 1'b0; p_chars = 0; p_faults = '0;
  endfunction

  function automatic void restart_msg();
    p_mode = bsv_pkg::MODE_EXPECT; p_depth = 0; clear_num();
    p_left = '0; p_top_done = 1'b0; p_err_hold = 1'b0;
  endfunction

  function automatic logic [1:0] slot_at_top();
    if (p_depth == 0 || p_depth > NEST) return bsv_pkg::SLOT_NONE;
    return p_stack[p_depth-1];
  endfunction

  // field-by-field comparison, returns the number of mismatching fields
  function automatic int tok_mismatches(string where, token_t e, token_t a);
    int n;
    n = 0;
    if (a.kind !== e.kind) begin
      $error("%s token_kind exp %0d got %0d", where, e.kind, a.kind); n++;
    end
    if (a.value !== e.value) begin
      $error("%s token_value exp %h got %h", where, e.value, a.value); n++;
    end
    if (a.level !== e.level) begin
      $error("%s nesting_level exp %0d got %0d", where, e.level, a.level); n++;
    end
    if (a.key !== e.key) begin
      $error("%s is_dict_key exp %0d got %0d", where, e.key, a.key); n++;
    end
    if (a.status !== e.status) begin
      $error("%s status exp %0d got %0d", where, e.status, a.status); n++;
    end
    if (a.done !== e.done) begin
      $error("%s message_done exp %0d got %0d", where, e.done, a.done); n++;
    end
    return n;
  endfunction

  // one digit or sign step of an integer or length
  function automatic void digit_step(logic [7:0] c, bit allow_minus);
    int unsigned pos;
    logic [63:0] d, lim;
    pos = p_chars;
    if (p_chars < CHARS) p_chars++;
    if (pos == 0 && c == bsv_pkg::CH_MINUS && allow_minus) p_neg = 1'b1;
    else if (c >= bsv_pkg::CH_0 && c <= bsv_pkg::CH_9) begin
      d = 64'(c - bsv_pkg::CH_0);
      lim = p_neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      if (pos > p_neg && p_mag == 0 && !(p_faults & bsv_pkg::FAULT_OVF))
        p_faults |= bsv_pkg::FAULT_ZERO;
      if (p_neg && pos == 1 && d == 0) p_faults |= bsv_pkg::FAULT_ZERO;
      if (!(p_faults & bsv_pkg::FAULT_OVF)) begin
        if (p_mag > (lim - d) / 10) p_faults |= bsv_pkg::FAULT_OVF;
        else p_mag = p_mag * 10 + d;
      end
    end else p_faults |= bsv_pkg::FAULT_BAD;
  endfunction

  function automatic bit num_rejected();
    return p_faults != 0 || p_chars == 0 || p_chars >= CHARS || p_chars == p_neg;
  endfunction

  function automatic void value_complete();
    p_mode = bsv_pkg::MODE_EXPECT;
    if (p_depth == 0) begin
      p_top_done = 1'b1;
      return;
    end
    if (p_depth > NEST) return;
    if (p_stack[p_depth-1] == bsv_pkg::SLOT_DKEY) p_stack[p_depth-1] = bsv_pkg::SLOT_DVAL;
    else if (p_stack[p_depth-1] == bsv_pkg::SLOT_DVAL) p_stack[p_depth-1] = bsv_pkg::SLOT_DKEY;
  endfunction

  // advance the predictor by one byte; returns 1 when a token results
  function automatic bit predict_token(logic [7:0] c, logic last, output token_t t);
    int unsigned lim;
    bit keyslot, have, done;
    t.kind = bsv_pkg::KIND_STATUS; t.value = '0; t.level = 9'(p_depth); t.key = 1'b0;
    t.status = bsv_pkg::ST_RUN; t.done = 1'b0;
    have = 1'b0; done = 1'b0;
    lim = (p_max_depth < NEST) ? p_max_depth : NEST;
    keyslot = slot_at_top() == bsv_pkg::SLOT_DKEY;
    if (p_err_hold) begin
      if (last) restart_msg();
      return 1'b0;
    end
    if (p_top_done) t.status = bsv_pkg::ST_TRAIL;
    else case (p_mode)
      bsv_pkg::MODE_EXPECT: begin
        if (c == bsv_pkg::CH_E && p_depth > 0 && slot_at_top() != bsv_pkg::SLOT_DVAL) begin
          p_depth--;
          have = 1'b1; t.kind = bsv_pkg::KIND_CLOSE; t.level = 9'(p_depth);
          value_complete();
        end else if (p_depth + 1 > lim) t.status = bsv_pkg::ST_DEEP;
        else if (c == bsv_pkg::CH_L || c == bsv_pkg::CH_D) begin
          if (keyslot || p_depth >= NEST) t.status = bsv_pkg::ST_INVALID;
          else begin
            have = 1'b1;
            t.kind = (c == bsv_pkg::CH_L) ? bsv_pkg::KIND_LIST : bsv_pkg::KIND_DICT;
            t.level = 9'(p_depth);
            p_stack[p_depth] = (c == bsv_pkg::CH_L) ? bsv_pkg::SLOT_LIST : bsv_pkg::SLOT_DKEY;
            p_depth++;
          end
        end else if (c == bsv_pkg::CH_I) begin
          clear_num(); p_mode = bsv_pkg::MODE_INT;
        end else if (c == bsv_pkg::CH_B) begin
          if (keyslot) t.status = bsv_pkg::ST_INVALID;
          else p_mode = bsv_pkg::MODE_BOOL;
        end else if (c >= bsv_pkg::CH_0 && c <= bsv_pkg::CH_9) begin
          clear_num(); p_mode = bsv_pkg::MODE_LEN; digit_step(c, 1'b0);
        end else t.status = bsv_pkg::ST_INVALID;
      end
      bsv_pkg::MODE_INT: begin
        if (c == bsv_pkg::CH_E) begin
          if (num_rejected()) t.status = bsv_pkg::ST_INVALID;
          else begin
            have = 1'b1; t.kind = bsv_pkg::KIND_INT; t.key = keyslot;
            t.value = p_neg ? -p_mag : p_mag;
            value_complete();
          end
        end else digit_step(c, 1'b1);
      end
      bsv_pkg::MODE_LEN: begin
        if (c == bsv_pkg::CH_COLON) begin
          if (num_rejected() || p_neg || (p_mag >> LBITS) != 0)
            t.status = bsv_pkg::ST_INVALID;
          else begin
            have = 1'b1; t.kind = bsv_pkg::KIND_LEN; t.key = keyslot; t.value = p_mag;
            if (p_mag == 0) value_complete();
            else begin
              p_left = p_mag; p_mode = bsv_pkg::MODE_STR;
            end
          end
        end else digit_step(c, 1'b0);
      end
      bsv_pkg::MODE_STR: begin
        have = 1'b1; t.kind = bsv_pkg::KIND_BYTE; t.key = keyslot; t.value = 64'(c);
        if (p_left > 0) p_left--;
        if (p_left == 0) value_complete();
      end
      bsv_pkg::MODE_BOOL: begin
        if (c == bsv_pkg::CH_0 || c == bsv_pkg::CH_1) begin
          have = 1'b1; t.kind = bsv_pkg::KIND_BOOL; t.value = 64'(c - bsv_pkg::CH_0);
          value_complete();
        end else t.status = bsv_pkg::ST_INVALID;
      end
      default: t.status = bsv_pkg::ST_INVALID;
    endcase
    if (t.status != bsv_pkg::ST_RUN) begin
      have = 1'b1; t.kind = bsv_pkg::KIND_STATUS; t.value = '0; t.key = 1'b0;
      t.level = 9'(p_depth); done = 1'b1;
    end else if (last) begin
      t.status = p_top_done ? bsv_pkg::ST_DONE : bsv_pkg::ST_SHORT;
      have = 1'b1; done = 1'b1;
    end
    t.done = done;
    if (done) begin
      if (last) restart_msg();
      else p_err_hold = 1'b1;
    end
    return have;
  endfunction

  // random gap, sometimes none; valid drops for the gap
  task automatic sender_gap();
    int n;
    if (!no_gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 19);
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // send one byte; the predictor runs on acceptance
  task automatic send_byte(logic [7:0] c, logic last);
    token_t t;
    sender_gap();
    in_tvalid <= 1'b1; in_tdata <= c; in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    if (predict_token(c, last, t)) expected_tokens.push_back(t);
  endtask

  task automatic send_str(string s, bit close_msg);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], close_msg && i == s.len() - 1);
  endtask

  task automatic drain_tokens();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_depth(logic [8:0] v);
    drain_tokens();
    cfg_valid <= 1'b1; cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_max_depth = v;
  endtask

  // receiver stall bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!no_gaps && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    token_t e, a;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected token %h", out_tdata);
        fail_count++;
      end else begin
        e = expected_tokens.pop_front();
        a.kind   = out_tdata[2:0];
        a.value  = out_tdata[66:3];
        a.level  = out_tdata[75:67];
        a.key    = out_tdata[76];
        a.status = out_tdata[79:77];
        a.done   = out_tlast;
        fail_count += tok_mismatches("result", e, a);
      end
    end
  end

  // watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // random well-formed value, with a nesting budget
  function automatic string rand_value(int lvl, bit want_key);
    string s;
    int n, k;
    longint v;
    k = want_key ? $urandom_range(2, 3) : $urandom_range(0, 5);
    if (lvl <= 0 && k < 2) k = 3;
    case (k)
      0: begin
        s = "l";
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) s = {s, rand_value(lvl - 1, 1'b0)};
        s = {s, "e"};
      end
      1: begin
        s = "d";
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
          s = {s, rand_value(lvl - 1, 1'b1), rand_value(lvl - 1, 1'b0)};
        s = {s, "e"};
      end
      2: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = $signed({$urandom, $urandom});
          default: v = $signed(32'($urandom)) >>> $urandom_range(0, 31);
        endcase
        s = $sformatf("i%0de", v);
      end
      3: begin
        n = $urandom_range(0, 4);
        s = $sformatf("%0d:", n);
        for (int i = 0; i < n; i++) s = {s, string'(8'($urandom))};
      end
      default: s = ($urandom_range(0, 1) != 0) ? "b1" : "b0";
    endcase
    return s;
  endfunction

  row_t rows[$];

  function automatic void add_row(logic [7:0] c, logic last);
    row_t r;
    r.ch = c; r.last = last; r.typed = 1'b0; r.has_tok = 1'b0;
    rows.push_back(r);
  endfunction

  function automatic void add_typed(logic [7:0] c, logic last, bit has, logic [2:0] kind,
                                    logic [63:0] val, logic [8:0] lvl, logic [2:0] st);
    row_t r;
    r.ch = c; r.last = last; r.typed = 1'b1; r.has_tok = has;
    r.tok.kind = kind; r.tok.value = val; r.tok.level = lvl; r.tok.key = 1'b0;
    r.tok.status = st; r.tok.done = (st != bsv_pkg::ST_RUN);
    rows.push_back(r);
  endfunction

  initial begin
    string s;
    token_t t;
    int items;
    rst_n = 1'b0; in_tvalid = 1'b0; in_tdata = '0; in_tlast = 1'b0;
    cfg_valid = 1'b0; cfg_data = '0;
    p_max_depth = 9'd256;
    restart_msg();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    add_typed("l", 1'b0, 1'b1, bsv_pkg::KIND_LIST, 0, 0, bsv_pkg::ST_RUN);
    add_typed("e", 1'b1, 1'b1, bsv_pkg::KIND_CLOSE, 0, 0, bsv_pkg::ST_DONE);
    // close at top level
    add_typed("e", 1'b1, 1'b1, bsv_pkg::KIND_STATUS, 0, 0, bsv_pkg::ST_INVALID);
    // bad start byte
    add_typed("x", 1'b0, 1'b1, bsv_pkg::KIND_STATUS, 0, 0, bsv_pkg::ST_INVALID);
    // swallowed after error
    add_typed(8'hff, 1'b1, 1'b0, bsv_pkg::KIND_STATUS, 0, 0, bsv_pkg::ST_RUN);
    // message ends early
    add_typed("i", 1'b1, 1'b1, bsv_pkg::KIND_STATUS, 0, 0, bsv_pkg::ST_SHORT);
    add_typed("b", 1'b0, 1'b0, bsv_pkg::KIND_STATUS, 0, 0, bsv_pkg::ST_RUN);
    add_typed("1", 1'b0, 1'b1, bsv_pkg::KIND_BOOL, 1, 0, bsv_pkg::ST_RUN);
    // trailing byte
    add_typed(8'h00, 1'b1, 1'b1, bsv_pkg::KIND_STATUS, 0, 0, bsv_pkg::ST_TRAIL);
    foreach (rows[i]) begin
      send_byte(rows[i].ch, rows[i].last);
      if (rows[i].typed && rows[i].has_tok) begin
        t = expected_tokens[$];
        fail_count += tok_mismatches($sformatf("table row %0d", i), rows[i].tok, t);
      end
    end
    // extremes of integers, zero rules, overlong numbers, dict key rules, oversized lengths, bad booleans
    send_str("i-9223372036854775808e", 1'b1);
    send_str("i9223372036854775807e", 1'b1);
    send_str("i9223372036854775808e", 1'b1);
    send_str("i-0e", 1'b1);
    send_str("i012e", 1'b1);
    send_str("i-e", 1'b1);
    send_str("ie", 1'b1);
    send_str("i1a2e", 1'b1);
    send_str("i000000000000000000001e", 1'b1);
    send_str("i1x", 1'b1);
    send_str("4294967296:", 1'b1);
    send_str("d1:ai-5ei7e3:xyze", 1'b1);
    send_str("dle", 1'b1);
    send_str("dbe", 1'b1);
    send_str("di1ee", 1'b1);
    send_str("0:", 1'b1);
    send_str("b2", 1'b1);

    // depth limits, the extremes included
    write_max_depth(9'd1);
    send_str("lle", 1'b1);
    send_str("i3e", 1'b1);
    write_max_depth(9'd0);
    send_str("i3e", 1'b1);
    write_max_depth(9'h1ff);
    s = "";
    for (int i = 0; i < 257; i++) s = {s, "l"};
    send_str(s, 1'b1);

    // random messages, depth limit changed between phases
    items = 0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_max_depth(9'd256);
        1: write_max_depth(9'd3);
        2: write_max_depth(9'($urandom_range(1, 255)));
        default: write_max_depth(9'd2);
      endcase
      if (ph == 3) no_gaps = 1'b1;
      while (items < (ph + 1) * 250) begin
        s = rand_value($urandom_range(0, 5), 1'b0);
        if ($urandom_range(0, 9) == 0) s = {s, string'(8'($urandom))};
        if ($urandom_range(0, 9) == 0 && s.len() > 1)
          s.putc($urandom_range(0, s.len() - 1), 8'($urandom));
        if ($urandom_range(0, 15) == 0 && s.len() > 1)
          s = s.substr(0, $urandom_range(0, s.len() - 2));
        send_str(s, 1'b1);
        items += s.len();
        // let the result side empty out with the sender held
        if ($urandom_range(0, 40) == 0) drain_tokens();
      end
    end

    drain_tokens();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_tokens.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire
